/* design/two_axis_stepper_move_limiter_assert.svh */
// assertion macros for the two-axis stepper move limiter
`ifndef TWO_AXIS_STEPPER_MOVE_LIMITER_ASSERT_SVH
`define TWO_AXIS_STEPPER_MOVE_LIMITER_ASSERT_SVH

`ifndef ASSERT_OFF
`define TSML_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("tsml assertion failed");
`define TSML_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("tsml assertion failed");
`else
`define TSML_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define TSML_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* design/tsml_pkg.sv */
// shared types and constants of the two-axis stepper move limiter
package tsml_pkg;

	localparam int MICROSTEPS      = 16;
	localparam int STEPS_PER_TURN  = 200;
	localparam int UNITS_PER_TURN  = 23040;
	localparam int PULSES_PER_TURN = STEPS_PER_TURN * MICROSTEPS;

	localparam int ANGLE_W = 14;
	localparam int DELTA_W = 14;
	localparam int PULSE_W = 12;
	localparam int SUM_W   = ANGLE_W + 2;

	localparam int unsigned PULSE_MAX = (1 << PULSE_W) - 1;

	// numerator of the rounded pulse count: delta * pulses_per_turn + half a turn
	localparam longint unsigned NUM_MAX =
		longint'((1 << DELTA_W) - 1) * PULSES_PER_TURN + UNITS_PER_TURN / 2;
	localparam int NUM_W = $clog2(NUM_MAX + 1);

	// reciprocal of units per turn, exact for every numerator below 2**NUM_W
	localparam int RECIP_SH = NUM_W + $clog2(UNITS_PER_TURN);
	localparam longint unsigned RECIP =
		((64'd1 << RECIP_SH) + UNITS_PER_TURN - 1) / UNITS_PER_TURN;
	localparam int RECIP_W = $clog2(RECIP + 1);
	localparam int PROD_W  = NUM_W + RECIP_W;
	localparam int QUO_W   = PROD_W - RECIP_SH;
	localparam int CMP_W   = (QUO_W > PULSE_W) ? QUO_W : PULSE_W;

	typedef logic signed [ANGLE_W-1:0] angle_t;
	typedef logic [DELTA_W-1:0] delta_t;
	typedef logic [PULSE_W-1:0] pulse_t;
	typedef logic [NUM_W-1:0] num_t;
	typedef logic [1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_UP_MAX   = 2'd0;
	localparam cfg_idx_t CFG_UP_MIN   = 2'd1;
	localparam cfg_idx_t CFG_DOWN_MAX = 2'd2;
	localparam cfg_idx_t CFG_DOWN_MIN = 2'd3;

	localparam logic OP_MOVE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam angle_t LIMIT_MAX_RST = 14'sd5760;
	localparam angle_t LIMIT_MIN_RST = -14'sd5760;

	typedef struct packed {
		logic   opcode;
		logic   axis;
		delta_t delta;
		logic   direction;
	} item_t;

	typedef struct packed {
		angle_t up_max;
		angle_t up_min;
		angle_t lower_max;
		angle_t lower_min;
	} limits_t;

	// result word, lowest field in the lowest bits
	typedef struct packed {
		logic [1:0] pad;
		angle_t     axis_angle;
		pulse_t     pulses_left;
		logic       dir_pin;
		logic       move_done;
		logic       step_pulse;
		logic       move_rejected;
	} result_t;

endpackage

/* design/tsml_cfg_regs.sv */
// angle limit registers written through the configuration channel
module tsml_cfg_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  tsml_pkg::cfg_idx_t cfg_index,
	input  tsml_pkg::angle_t   cfg_data,
	output tsml_pkg::limits_t  limits
);

	tsml_pkg::limits_t limits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q.up_max    <= tsml_pkg::LIMIT_MAX_RST;
			limits_q.up_min    <= tsml_pkg::LIMIT_MIN_RST;
			limits_q.lower_max <= tsml_pkg::LIMIT_MAX_RST;
			limits_q.lower_min <= tsml_pkg::LIMIT_MIN_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				tsml_pkg::CFG_UP_MAX:   limits_q.up_max    <= cfg_data;
				tsml_pkg::CFG_UP_MIN:   limits_q.up_min    <= cfg_data;
				tsml_pkg::CFG_DOWN_MAX: limits_q.lower_max <= cfg_data;
				tsml_pkg::CFG_DOWN_MIN: limits_q.lower_min <= cfg_data;
				default:                limits_q           <= limits_q;
			endcase
		end
	end

	assign limits = limits_q;

endmodule

/* design/tsml_in_stage.sv */
// input register: unpacks a request and forms the pulse-count numerator
module tsml_in_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [15:0]         s_axis_tdata,
	input  logic [1:0]          s_axis_tuser,
	input  logic                advance,
	output logic                valid_s1,
	output tsml_pkg::item_t     item_s1,
	output tsml_pkg::num_t      num_s1
);

	logic            take;
	tsml_pkg::item_t item_in;
	tsml_pkg::num_t  num_in;

	assign s_axis_tready = !valid_s1 || advance;
	assign take          = s_axis_tvalid && s_axis_tready;

	always_comb begin
		item_in.opcode    = s_axis_tuser[0];
		item_in.axis      = s_axis_tuser[1];
		item_in.delta     = s_axis_tdata[tsml_pkg::DELTA_W-1:0];
		item_in.direction = s_axis_tdata[tsml_pkg::DELTA_W];
		// constant scale plus half a turn for round half up
		num_in = tsml_pkg::NUM_W'(item_in.delta) * tsml_pkg::NUM_W'(tsml_pkg::PULSES_PER_TURN)
			+ tsml_pkg::NUM_W'(tsml_pkg::UNITS_PER_TURN / 2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item_in;
			num_s1  <= num_in;
		end
	end

endmodule

/* design/tsml_pulse_calc.sv */
// pulse count from the numerator: reciprocal multiply and saturation
module tsml_pulse_calc (
	input  tsml_pkg::num_t   num,
	output tsml_pkg::pulse_t pulses
);

	logic [tsml_pkg::PROD_W-1:0] prod;
	logic [tsml_pkg::QUO_W-1:0]  quo;
	logic [tsml_pkg::CMP_W-1:0]  quo_x;

	always_comb begin
		prod  = tsml_pkg::PROD_W'(num) * tsml_pkg::PROD_W'(tsml_pkg::RECIP);
		quo   = prod[tsml_pkg::PROD_W-1:tsml_pkg::RECIP_SH];
		quo_x = tsml_pkg::CMP_W'(quo);
		if (quo_x > tsml_pkg::CMP_W'(tsml_pkg::PULSE_MAX)) begin
			pulses = tsml_pkg::PULSE_W'(tsml_pkg::PULSE_MAX);
		end else begin
			pulses = tsml_pkg::PULSE_W'(quo_x);
		end
	end

endmodule

/* design/tsml_axis_core.sv */
// axis state, limit check, tick handling and result register
module tsml_axis_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_s1,
	input  tsml_pkg::item_t   item_s1,
	input  tsml_pkg::pulse_t  move_pulses,
	input  tsml_pkg::limits_t limits,
	output logic              advance,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [31:0]       m_axis_tdata
);

	tsml_pkg::angle_t angle_q [2];
	tsml_pkg::pulse_t pulses_q [2];
	logic             dir_q [2];

	tsml_pkg::result_t res_q;
	logic              res_valid_q;

	tsml_pkg::angle_t cur_angle;
	tsml_pkg::pulse_t cur_pulses;
	logic             cur_dir;
	tsml_pkg::angle_t lim_max;
	tsml_pkg::angle_t lim_min;

	logic signed [tsml_pkg::SUM_W-1:0] angle_x;
	logic signed [tsml_pkg::SUM_W-1:0] delta_x;
	logic signed [tsml_pkg::SUM_W-1:0] target;
	logic                              rejected;

	tsml_pkg::angle_t  nxt_angle;
	tsml_pkg::pulse_t  nxt_pulses;
	logic              nxt_dir;
	tsml_pkg::result_t res_d;

	assign advance = valid_s1 && (!res_valid_q || m_axis_tready);

	always_comb begin
		cur_angle  = angle_q[item_s1.axis];
		cur_pulses = pulses_q[item_s1.axis];
		cur_dir    = dir_q[item_s1.axis];
		lim_max    = item_s1.axis ? limits.lower_max : limits.up_max;
		lim_min    = item_s1.axis ? limits.lower_min : limits.up_min;

		// full-precision target so the compare cannot wrap
		angle_x = tsml_pkg::SUM_W'(cur_angle);
		delta_x = $signed(tsml_pkg::SUM_W'(item_s1.delta));
		target  = item_s1.direction ? angle_x + delta_x : angle_x - delta_x;
		rejected = item_s1.direction ? (target > tsml_pkg::SUM_W'(lim_max))
			: (target < tsml_pkg::SUM_W'(lim_min));

		nxt_angle  = cur_angle;
		nxt_pulses = cur_pulses;
		nxt_dir    = cur_dir;
		res_d      = '0;

		unique case (item_s1.opcode)
			tsml_pkg::OP_MOVE: begin
				if (rejected) begin
					res_d.move_rejected = 1'b1;
				end else begin
					nxt_angle  = target[tsml_pkg::ANGLE_W-1:0];
					nxt_pulses = move_pulses;
					nxt_dir    = item_s1.direction;
				end
			end
			tsml_pkg::OP_TICK: begin
				if (cur_pulses != '0) begin
					nxt_pulses       = cur_pulses - tsml_pkg::PULSE_W'(1);
					res_d.step_pulse = 1'b1;
					res_d.move_done  = (cur_pulses == tsml_pkg::PULSE_W'(1));
				end
			end
			default: begin
				res_d = '0;
			end
		endcase

		res_d.dir_pin     = nxt_dir;
		res_d.pulses_left = nxt_pulses;
		res_d.axis_angle  = nxt_angle;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q[0]  <= '0;
			angle_q[1]  <= '0;
			pulses_q[0] <= '0;
			pulses_q[1] <= '0;
			dir_q[0]    <= 1'b0;
			dir_q[1]    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				angle_q[item_s1.axis]  <= nxt_angle;
				pulses_q[item_s1.axis] <= nxt_pulses;
				dir_q[item_s1.axis]    <= nxt_dir;
				res_valid_q            <= 1'b1;
			end else if (m_axis_tready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign m_axis_tvalid = res_valid_q;
	assign m_axis_tdata  = res_q;

endmodule

/* design/two_axis_stepper_move_limiter.sv */
// top level of the two-axis stepper move limiter
//
// Two stepper axes, each with an absolute angle, a pending-pulse counter and a
// latched direction. A move request (tuser[0] = 0) is checked against the
// axis limits and, when it fits, updates the angle and direction and reloads
// the counter with the rounded pulse count; a tick request (tuser[0] = 1)
// consumes one pending pulse. Every request yields exactly one result that
// shows the addressed axis after the request. One request is taken every
// clock while the output is not stalled; a request is held in the input
// register, then the limit compare and the state update of the axis
// registers load the result register. The pulse count is a reciprocal
// multiply behind the input register. Limit registers may be written only
// while no request is in flight; cfg_ready is always high.
`include "two_axis_stepper_move_limiter_assert.svh"

module two_axis_stepper_move_limiter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // delta_angle[13:0], direction[14], zero[15]
	input  logic [1:0]  s_axis_tuser,  // opcode[0], axis[1]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// move_rejected[0], step_pulse[1], move_done[2], dir_pin[3],
	// pulses_left[15:4], axis_angle[29:16], zero[31:30]
	output logic [31:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [13:0] cfg_data
);

	tsml_pkg::limits_t limits;
	tsml_pkg::item_t   item_s1;
	tsml_pkg::num_t    num_s1;
	tsml_pkg::pulse_t  move_pulses;
	logic              valid_s1;
	logic              advance;

	assign cfg_ready = 1'b1;

	tsml_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.limits    (limits)
	);

	tsml_in_stage u_in_stage (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.advance       (advance),
		.valid_s1      (valid_s1),
		.item_s1       (item_s1),
		.num_s1        (num_s1)
	);

	tsml_pulse_calc u_pulse_calc (
		.num    (num_s1),
		.pulses (move_pulses)
	);

	tsml_axis_core u_axis_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.valid_s1      (valid_s1),
		.item_s1       (item_s1),
		.move_pulses   (move_pulses),
		.limits        (limits),
		.advance       (advance),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// a rejected move never steps and a finished move has nothing left
	`TSML_ASSERT_IMPLY(a_reject_no_step, clk, arst_n, m_axis_tvalid && m_axis_tdata[0], m_axis_tdata[2:1] == 2'b00)
	`TSML_ASSERT_IMPLY(a_done_empty, clk, arst_n, m_axis_tvalid && m_axis_tdata[2], m_axis_tdata[1] && (m_axis_tdata[15:4] == 12'd0))
	// a tick on a busy axis shows one pulse fewer in its result
	`TSML_ASSERT_NEXT(a_tick_counts, clk, arst_n, advance && (item_s1.opcode == tsml_pkg::OP_TICK) && (u_axis_core.cur_pulses != 12'd0), m_axis_tvalid && (m_axis_tdata[15:4] == $past(u_axis_core.cur_pulses) - 12'd1))

endmodule

/* tb/tb_two_axis_stepper_move_limiter.sv */
// testbench for the two-axis stepper move limiter: directed corners, limit settings and random traffic
module tb_two_axis_stepper_move_limiter;
	import tsml_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;  // delta_angle[13:0], direction[14], zero[15]
	logic [1:0]  s_axis_tuser;  // opcode[0], axis[1]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// move_rejected[0], step_pulse[1], move_done[2], dir_pin[3],
	// pulses_left[15:4], axis_angle[29:16], zero[31:30]
	logic [31:0] m_axis_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	cfg_idx_t    cfg_index;
	logic [13:0] cfg_data;

	// predicted axis state, index 0 upper, 1 lower
	angle_t axis_pos [2];
	pulse_t axis_pend [2];
	logic   axis_dir [2];
	angle_t lim_hi [2];
	angle_t lim_lo [2];

	result_t expected_status [$];
	result_t got_status;
	result_t want_status;

	int mismatches = 0;
	int cycle_count = 0;
	int send_gap_pct;
	int recv_stall_pct;

	two_axis_stepper_move_limiter u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// works out the status of the addressed axis after one request
	function automatic void apply_to_axes(logic op, logic ax, delta_t dl, logic dr);
		result_t r;
		int      target;
		longint  cnt;
		r = '0;
		if (op == OP_MOVE) begin
			target = dr ? int'(axis_pos[ax]) + int'(dl) : int'(axis_pos[ax]) - int'(dl);
			if (dr ? (target > int'(lim_hi[ax])) : (target < int'(lim_lo[ax]))) begin
				r.move_rejected = 1'b1;
			end else begin
				axis_pos[ax] = angle_t'(target);
				axis_dir[ax] = dr;
				cnt = (longint'(dl) * PULSES_PER_TURN + UNITS_PER_TURN / 2) / UNITS_PER_TURN;
				axis_pend[ax] = (cnt > PULSE_MAX) ? pulse_t'(PULSE_MAX) : pulse_t'(cnt);
			end
		end else if (axis_pend[ax] != '0) begin
			axis_pend[ax] = axis_pend[ax] - 1'b1;
			r.step_pulse = 1'b1;
			r.move_done = (axis_pend[ax] == '0);
		end
		r.dir_pin = axis_dir[ax];
		r.pulses_left = axis_pend[ax];
		r.axis_angle = axis_pos[ax];
		expected_status.push_back(r);
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_status = result_t'(m_axis_tdata);
			if (expected_status.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h with no request pending", m_axis_tdata);
			end else begin
				want_status = expected_status.pop_front();
				if (got_status.move_rejected !== want_status.move_rejected ||
				    got_status.step_pulse !== want_status.step_pulse ||
				    got_status.move_done !== want_status.move_done ||
				    got_status.dir_pin !== want_status.dir_pin ||
				    got_status.pulses_left !== want_status.pulses_left ||
				    got_status.axis_angle !== want_status.axis_angle ||
				    got_status.pad !== 2'b00) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp rej=%0b step=%0b done=%0b dir=%0b left=%0d ang=%0d pad=0 / got rej=%0b step=%0b done=%0b dir=%0b left=%0d ang=%0d pad=%0d",
							want_status.move_rejected, want_status.step_pulse,
							want_status.move_done, want_status.dir_pin,
							want_status.pulses_left, want_status.axis_angle,
							got_status.move_rejected, got_status.step_pulse,
							got_status.move_done, got_status.dir_pin,
							got_status.pulses_left, got_status.axis_angle, got_status.pad);
				end
			end
		end
	end

	task automatic send_request(input logic op, input logic ax, input delta_t dl, input logic dr);
		@(negedge clk);
		while ($urandom_range(99) < send_gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= {ax, op};
		s_axis_tdata <= {1'b0, dr, dl};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		apply_to_axes(op, ax, dl, dr);
	endtask

	// stop sending and let every pending result come back
	task automatic drain_results();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (expected_status.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_limit(input cfg_idx_t idx, input int value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 14'(value);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_UP_MAX: lim_hi[0] = angle_t'(value);
			CFG_UP_MIN: lim_lo[0] = angle_t'(value);
			CFG_DOWN_MAX: lim_hi[1] = angle_t'(value);
			default: lim_lo[1] = angle_t'(value);
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_all_limits(input int up_hi, input int up_lo, input int dn_hi,
	                                input int dn_lo);
		write_limit(CFG_UP_MAX, up_hi);
		write_limit(CFG_UP_MIN, up_lo);
		write_limit(CFG_DOWN_MAX, dn_hi);
		write_limit(CFG_DOWN_MIN, dn_lo);
	endtask

	// mostly a sane window around zero, now and then any value in range
	function automatic int pick_limit(logic upper_side);
		if ($urandom_range(3) == 0)
			return int'($urandom_range(11520)) - 5760;
		return upper_side ? int'($urandom_range(5760)) : -int'($urandom_range(5760));
	endfunction

	task automatic test_reset_and_moves();
		send_gap_pct = 8;
		recv_stall_pct = 68;
		send_request(OP_TICK, 1'b0, 14'd0, 1'b0);      // tick on idle axis right after reset
		send_request(OP_MOVE, 1'b0, 14'd0, 1'b1);      // zero-size move
		send_request(OP_MOVE, 1'b0, 14'd3, 1'b1);      // pulse count rounds to zero
		send_request(OP_MOVE, 1'b0, 14'd4, 1'b1);
		send_request(OP_TICK, 1'b0, 14'd0, 1'b0);      // last pulse, move done
		send_request(OP_MOVE, 1'b0, 14'd5756, 1'b1);   // overshoots the upper limit, rejected
		send_request(OP_MOVE, 1'b0, 14'd1, 1'b1);      // small step up, accepted
		send_request(OP_MOVE, 1'b0, 14'd0, 1'b1);      // zero move, clears pending
		send_request(OP_MOVE, 1'b0, 14'd11520, 1'b0);  // full swing down, rejected beyond the lower limit
		send_request(OP_MOVE, 1'b0, 14'd1, 1'b0);
		send_request(OP_TICK, 1'b0, 14'd0, 1'b1);
		send_request(OP_MOVE, 1'b1, 14'd18, 1'b1);     // exact half pulse rounds up
		send_request(OP_TICK, 1'b1, 14'd0, 1'b0);
		send_request(OP_TICK, 1'b1, 14'd0, 1'b1);
		send_request(OP_TICK, 1'b1, 14'd0, 1'b0);
		send_request(OP_TICK, 1'b1, 14'd0, 1'b0);
		send_request(OP_MOVE, 1'b1, 14'd8192, 1'b0);
		send_request(OP_MOVE, 1'b1, 14'd11520, 1'b1);
		drain_results();
	endtask

	task automatic test_limit_corners();
		// inverted window at the extremes
		write_all_limits(-5760, 5760, -5760, 5760);
		send_request(OP_MOVE, 1'b0, 14'd0, 1'b0);      // zero move rejected beyond min
		send_request(OP_MOVE, 1'b0, 14'd0, 1'b1);
		send_request(OP_MOVE, 1'b0, 14'd1, 1'b1);
		send_request(OP_MOVE, 1'b1, 14'd0, 1'b1);      // zero move rejected beyond max
		send_request(OP_MOVE, 1'b1, 14'd0, 1'b0);
		drain_results();
	endtask

	task automatic test_random_traffic(input int gap_pct, input int stall_pct, input int n_req);
		logic   op;
		logic   ax;
		logic   dr;
		delta_t dl;
		send_gap_pct = gap_pct;
		recv_stall_pct = stall_pct;
		for (int i = 0; i < n_req; i++) begin
			if (i == n_req / 2)
				drain_results();
			op = ($urandom_range(99) < 40) ? OP_MOVE : OP_TICK;
			ax = 1'($urandom_range(1));
			dr = 1'($urandom_range(1));
			case ($urandom_range(9))
				0: dl = delta_t'($urandom_range(11520));
				1: dl = $urandom_range(1) ? 14'd11520 : 14'd0;
				default: dl = delta_t'($urandom_range(80));
			endcase
			send_request(op, ax, dl, dr);
		end
		drain_results();
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_UP_MAX;
		cfg_data = '0;
		send_gap_pct = 0;
		recv_stall_pct = 0;
		for (int a = 0; a < 2; a++) begin
			axis_pos[a] = '0;
			axis_pend[a] = '0;
			axis_dir[a] = 1'b0;
			lim_hi[a] = LIMIT_MAX_RST;
			lim_lo[a] = LIMIT_MIN_RST;
		end
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_and_moves();
		test_limit_corners();
		write_all_limits(5760, -5760, 5760, -5760);
		test_random_traffic(8, 68, 280);
		write_all_limits(pick_limit(1'b1), pick_limit(1'b0), pick_limit(1'b1), pick_limit(1'b0));
		test_random_traffic(68, 8, 280);
		write_all_limits(pick_limit(1'b1), pick_limit(1'b0), pick_limit(1'b1), pick_limit(1'b0));
		test_random_traffic(0, 0, 290);

		if (mismatches == 0 && expected_status.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
